// ===== rtl/llcp_pkg.sv =====
// Shared constants, status codes and types of the line-line closest point block.
`timescale 1ns / 1ps

package llcp_pkg;

	localparam int LLCP_COORD_WIDTH = 32;
	localparam int LLCP_FRAC_BITS = 16;
	localparam int LLCP_QUEUE_DEPTH = 4;
	localparam int LLCP_TOL_WIDTH = 31;
	localparam int LLCP_DOT_WIDTH = 64;
	localparam logic [LLCP_TOL_WIDTH-1:0] LLCP_TOL_RESET = 31'd66;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_B_DEGEN  = 2'd1,
		ST_A_DEGEN  = 2'd2,
		ST_PARALLEL = 2'd3
	} llcp_status_t;

endpackage

// ===== rtl/llcp_fifo.sv =====
// Small register queue between the classifying front and the arithmetic back.
`timescale 1ns / 1ps

module llcp_fifo import llcp_pkg::*; #(
	parameter int W = 8,
	parameter int DEPTH = LLCP_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         full,
	output logic         empty
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW:0]  wr_q;
	logic [AW:0]  rd_q;

	assign full  = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
	assign empty = (wr_q == rd_q);
	assign dout  = mem_q[rd_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q[AW-1:0]] <= din;
		end
	end

endmodule

// ===== rtl/llcp_front.sv =====
// Front end: direction vectors of both lines and the degenerate-line classification.
`timescale 1ns / 1ps

module llcp_front import llcp_pkg::*; #(
	parameter int COORD_WIDTH = LLCP_COORD_WIDTH
) (
	input  logic signed [COORD_WIDTH-1:0]    a_start_x,
	input  logic signed [COORD_WIDTH-1:0]    a_start_y,
	input  logic signed [COORD_WIDTH-1:0]    a_start_z,
	input  logic signed [COORD_WIDTH-1:0]    a_end_x,
	input  logic signed [COORD_WIDTH-1:0]    a_end_y,
	input  logic signed [COORD_WIDTH-1:0]    a_end_z,
	input  logic signed [COORD_WIDTH-1:0]    b_start_x,
	input  logic signed [COORD_WIDTH-1:0]    b_start_y,
	input  logic signed [COORD_WIDTH-1:0]    b_start_z,
	input  logic signed [COORD_WIDTH-1:0]    b_end_x,
	input  logic signed [COORD_WIDTH-1:0]    b_end_y,
	input  logic signed [COORD_WIDTH-1:0]    b_end_z,
	input  logic [LLCP_TOL_WIDTH-1:0]        tol,
	output logic [6*COORD_WIDTH+9*(COORD_WIDTH+1)+1:0] entry
);

	localparam int CW = COORD_WIDTH;
	localparam int D  = CW + 1;
	localparam int MW = (D > LLCP_TOL_WIDTH) ? D : LLCP_TOL_WIDTH;

	logic signed [CW-1:0] p1 [3];
	logic signed [CW-1:0] p2 [3];
	logic signed [CW-1:0] p3 [3];
	logic signed [CW-1:0] p4 [3];
	logic signed [D-1:0]  d13 [3];
	logic signed [D-1:0]  d43 [3];
	logic signed [D-1:0]  d21 [3];
	logic [2:0]           small43;
	logic [2:0]           small21;
	logic [1:0]           st;

	function automatic logic is_small(input logic signed [D-1:0] v,
			input logic [LLCP_TOL_WIDTH-1:0] t);
		logic [D-1:0] mag;
		mag = v[D-1] ? (~v + 1'b1) : v;
		return MW'(mag) < MW'(t);
	endfunction

	assign p1 = '{a_start_x, a_start_y, a_start_z};
	assign p2 = '{a_end_x, a_end_y, a_end_z};
	assign p3 = '{b_start_x, b_start_y, b_start_z};
	assign p4 = '{b_end_x, b_end_y, b_end_z};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			d13[c] = D'(p1[c]) - D'(p3[c]);
			d43[c] = D'(p4[c]) - D'(p3[c]);
			d21[c] = D'(p2[c]) - D'(p1[c]);
			small43[c] = is_small(d43[c], tol);
			small21[c] = is_small(d21[c], tol);
		end
		if (&small43) begin
			st = ST_B_DEGEN;
		end else if (&small21) begin
			st = ST_A_DEGEN;
		end else begin
			st = ST_OK;
		end
	end

	assign entry = {st, p1[0], p1[1], p1[2], p3[0], p3[1], p3[2],
		d13[0], d13[1], d13[2], d43[0], d43[1], d43[2], d21[0], d21[1], d21[2]};

endmodule

// ===== rtl/llcp_mul.sv =====
// Two-stage signed multiplier built from four registered partial products.
`timescale 1ns / 1ps

module llcp_mul import llcp_pkg::*; #(
	parameter int AW = LLCP_DOT_WIDTH,
	parameter int BW = LLCP_DOT_WIDTH
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	localparam int PW  = AW + BW;
	localparam int AL  = (AW + 1) / 2;
	localparam int AHI = AW - AL;
	localparam int BL  = (BW + 1) / 2;
	localparam int BHI = BW - BL;

	logic [AW-1:0]      a_mag;
	logic [BW-1:0]      b_mag;
	logic [AL+BL-1:0]   pp_ll_s1;
	logic [AL+BHI-1:0]  pp_lh_s1;
	logic [AHI+BL-1:0]  pp_hl_s1;
	logic [AHI+BHI-1:0] pp_hh_s1;
	logic               neg_s1;
	logic [PW-1:0]      sum;
	logic signed [PW-1:0] p_s2;

	assign a_mag = a[AW-1] ? (~a + 1'b1) : a;
	assign b_mag = b[BW-1] ? (~b + 1'b1) : b;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= a_mag[AL-1:0] * b_mag[BL-1:0];
			pp_lh_s1 <= a_mag[AL-1:0] * b_mag[BW-1:BL];
			pp_hl_s1 <= a_mag[AW-1:AL] * b_mag[BL-1:0];
			pp_hh_s1 <= a_mag[AW-1:AL] * b_mag[BW-1:BL];
			neg_s1   <= a[AW-1] ^ b[BW-1];
		end
	end

	assign sum = PW'(pp_ll_s1) + (PW'(pp_lh_s1) << BL) + (PW'(pp_hl_s1) << AL)
		+ (PW'(pp_hh_s1) << (AL + BL));

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= neg_s1 ? (~sum + 1'b1) : sum;
		end
	end

	assign p = p_s2;

endmodule

// ===== rtl/llcp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag and tag.
`timescale 1ns / 1ps

module llcp_div import llcp_pkg::*; #(
	parameter int NW = 2 * LLCP_DOT_WIDTH + 1,
	parameter int DW = 2 * LLCP_DOT_WIDTH + 1,
	parameter int QW = LLCP_COORD_WIDTH,
	parameter int SH = LLCP_FRAC_BITS,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	input  logic [TW-1:0] tin,
	output logic          vout,
	output logic [QW-1:0] q,
	output logic          ovf,
	output logic [TW-1:0] tout
);

	localparam int XW = NW + SH;
	localparam int MW = (XW > DW) ? XW : DW;

	logic [XW-1:0] x;
	logic [XW-1:0] hi;

	logic          v_s  [QW+1];
	logic [DW-1:0] rem_s [QW+1];
	logic [DW-1:0] d_s  [QW+1];
	logic [QW-1:0] qb_s [QW+1];
	logic [QW-1:0] xl_s [QW+1];
	logic          ov_s [QW+1];
	logic [TW-1:0] tg_s [QW+1];

	assign x  = XW'(n) << SH;
	assign hi = x >> QW;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= hi[DW-1:0];
			d_s[0]   <= d;
			qb_s[0]  <= '0;
			xl_s[0]  <= x[QW-1:0];
			ov_s[0]  <= MW'(hi) >= MW'(d);
			tg_s[0]  <= tin;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0] r;
		logic        ge;

		assign r  = {rem_s[k], xl_s[k][QW-1-k]};
		assign ge = r >= {1'b0, d_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DW'(r - {1'b0, d_s[k]}) : DW'(r);
				d_s[k+1]   <= d_s[k];
				qb_s[k+1]  <= {qb_s[k][QW-2:0], ge};
				xl_s[k+1]  <= xl_s[k];
				ov_s[k+1]  <= ov_s[k];
				tg_s[k+1]  <= tg_s[k];
			end
		end
	end

	assign vout = v_s[QW];
	assign q    = qb_s[QW];
	assign ovf  = ov_s[QW];
	assign tout = tg_s[QW];

endmodule

// ===== rtl/llcp_back.sv =====
// Back end: dot products, both parameters by division, and the two closest points.
`timescale 1ns / 1ps

module llcp_back import llcp_pkg::*; #(
	parameter int COORD_WIDTH = LLCP_COORD_WIDTH,
	parameter int FRAC_BITS = LLCP_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [LLCP_TOL_WIDTH-1:0]     tol,
	input  logic                          in_valid,
	input  logic [6*COORD_WIDTH+9*(COORD_WIDTH+1)+1:0] entry,
	output logic                          in_take,
	input  logic                          out_pop,
	output logic                          out_valid,
	output logic [1:0]                    status,
	output logic signed [COORD_WIDTH-1:0] near_a [3],
	output logic signed [COORD_WIDTH-1:0] near_b [3],
	output logic signed [COORD_WIDTH-1:0] param_a,
	output logic signed [COORD_WIDTH-1:0] param_b
);

	localparam int CW  = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int D   = CW + 1;
	localparam int PW  = 2 * D;
	localparam int SW  = PW + 2;
	localparam int DTW = LLCP_DOT_WIDTH;
	localparam int XW  = (SW > DTW) ? SW : DTW;
	localparam int DNW = 2 * DTW + 1;
	localparam int N2W = (((DTW + F) > (DTW + CW)) ? (DTW + F) : (DTW + CW)) + 1;
	localparam int PSW = (((CW + F) > (2 * CW + 1)) ? (CW + F) : (2 * CW + 1)) + 1;
	localparam int TW1 = 6 * CW + 6 * D + 2 + 3 * DTW + 1;
	localparam int TW2 = 3 * CW + 3 * CW + 3 * D + 2 + CW + 1;

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW:0] POS_LIM = {2'b00, {(CW-1){1'b1}}};
	localparam logic [CW:0] NEG_LIM = {2'b01, {(CW-1){1'b0}}};
	localparam logic signed [DTW-1:0] DMAX = {1'b0, {(DTW-1){1'b1}}};
	localparam logic signed [DTW-1:0] DMIN = {1'b1, {(DTW-1){1'b0}}};

	function automatic logic signed [DTW-1:0] dot_sat(input logic signed [PW-1:0] x0,
			input logic signed [PW-1:0] x1, input logic signed [PW-1:0] x2);
		logic signed [SW-1:0] s;
		logic signed [XW-1:0] e;
		s = SW'(x0) + SW'(x1) + SW'(x2);
		s = s >>> F;
		e = XW'(s);
		if (&e[XW-1:DTW-1] || ~|e[XW-1:DTW-1]) begin
			return e[DTW-1:0];
		end
		return e[XW-1] ? DMIN : DMAX;
	endfunction

	function automatic logic signed [CW-1:0] sat_q(input logic ov, input logic [CW-1:0] qv,
			input logic neg);
		logic [CW:0] mag;
		mag = {ov, qv};
		if (!neg) begin
			return (mag > POS_LIM) ? CMAX : qv;
		end
		return (mag > NEG_LIM) ? CMIN : (~qv + 1'b1);
	endfunction

	function automatic logic signed [CW-1:0] sat_pt(input logic signed [PSW-1:0] v);
		if (&v[PSW-1:CW-1] || ~|v[PSW-1:CW-1]) begin
			return v[CW-1:0];
		end
		return v[PSW-1] ? CMIN : CMAX;
	endfunction

	logic en;

	logic [1:0]           st_in;
	logic signed [CW-1:0] p1_in [3];
	logic signed [CW-1:0] p3_in [3];
	logic signed [D-1:0]  d13_in [3];
	logic signed [D-1:0]  d43_in [3];
	logic signed [D-1:0]  d21_in [3];

	assign en        = !out_valid || out_pop;
	assign in_take   = en && in_valid;
	assign {st_in, p1_in[0], p1_in[1], p1_in[2], p3_in[0], p3_in[1], p3_in[2],
		d13_in[0], d13_in[1], d13_in[2], d43_in[0], d43_in[1], d43_in[2],
		d21_in[0], d21_in[1], d21_in[2]} = entry;

	// Dot product terms.
	logic signed [PW-1:0] pr1343 [3];
	logic signed [PW-1:0] pr4321 [3];
	logic signed [PW-1:0] pr1321 [3];
	logic signed [PW-1:0] pr4343 [3];
	logic signed [PW-1:0] pr2121 [3];

	for (genvar c = 0; c < 3; c++) begin : g_dot
		llcp_mul #(.AW(D), .BW(D)) u_m1343 (.clk, .en, .a(d13_in[c]), .b(d43_in[c]),
			.p(pr1343[c]));
		llcp_mul #(.AW(D), .BW(D)) u_m4321 (.clk, .en, .a(d43_in[c]), .b(d21_in[c]),
			.p(pr4321[c]));
		llcp_mul #(.AW(D), .BW(D)) u_m1321 (.clk, .en, .a(d13_in[c]), .b(d21_in[c]),
			.p(pr1321[c]));
		llcp_mul #(.AW(D), .BW(D)) u_m4343 (.clk, .en, .a(d43_in[c]), .b(d43_in[c]),
			.p(pr4343[c]));
		llcp_mul #(.AW(D), .BW(D)) u_m2121 (.clk, .en, .a(d21_in[c]), .b(d21_in[c]),
			.p(pr2121[c]));
	end

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [1:0]           st_s1, st_s2, st_s3, st_s4, st_s5, st_s6;
	logic signed [CW-1:0] p1_s1 [3], p1_s2 [3], p1_s3 [3], p1_s4 [3], p1_s5 [3], p1_s6 [3];
	logic signed [CW-1:0] p3_s1 [3], p3_s2 [3], p3_s3 [3], p3_s4 [3], p3_s5 [3], p3_s6 [3];
	logic signed [D-1:0]  d21_s1 [3], d21_s2 [3], d21_s3 [3], d21_s4 [3], d21_s5 [3];
	logic signed [D-1:0]  d21_s6 [3];
	logic signed [D-1:0]  d43_s1 [3], d43_s2 [3], d43_s3 [3], d43_s4 [3], d43_s5 [3];
	logic signed [D-1:0]  d43_s6 [3];
	logic signed [DTW-1:0] d1343_s3, d4321_s3, d1321_s3, d4343_s3, d2121_s3;
	logic signed [DTW-1:0] d1343_s4, d4321_s4, d4343_s4;
	logic signed [DTW-1:0] d1343_s5, d4321_s5, d4343_s5;
	logic signed [DTW-1:0] d1343_s6, d4321_s6, d4343_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1  <= st_in;
			p1_s1  <= p1_in;
			p3_s1  <= p3_in;
			d21_s1 <= d21_in;
			d43_s1 <= d43_in;
			st_s2  <= st_s1;
			p1_s2  <= p1_s1;
			p3_s2  <= p3_s1;
			d21_s2 <= d21_s1;
			d43_s2 <= d43_s1;
			st_s3  <= st_s2;
			p1_s3  <= p1_s2;
			p3_s3  <= p3_s2;
			d21_s3 <= d21_s2;
			d43_s3 <= d43_s2;
			d1343_s3 <= dot_sat(pr1343[0], pr1343[1], pr1343[2]);
			d4321_s3 <= dot_sat(pr4321[0], pr4321[1], pr4321[2]);
			d1321_s3 <= dot_sat(pr1321[0], pr1321[1], pr1321[2]);
			d4343_s3 <= dot_sat(pr4343[0], pr4343[1], pr4343[2]);
			d2121_s3 <= dot_sat(pr2121[0], pr2121[1], pr2121[2]);
			st_s4  <= st_s3;
			p1_s4  <= p1_s3;
			p3_s4  <= p3_s3;
			d21_s4 <= d21_s3;
			d43_s4 <= d43_s3;
			d1343_s4 <= d1343_s3;
			d4321_s4 <= d4321_s3;
			d4343_s4 <= d4343_s3;
			st_s5  <= st_s4;
			p1_s5  <= p1_s4;
			p3_s5  <= p3_s4;
			d21_s5 <= d21_s4;
			d43_s5 <= d43_s4;
			d1343_s5 <= d1343_s4;
			d4321_s5 <= d4321_s4;
			d4343_s5 <= d4343_s4;
		end
	end

	// Denominator and numerator of the first parameter.
	logic signed [2*DTW-1:0] pden0, pden1, pnum0, pnum1;

	llcp_mul #(.AW(DTW), .BW(DTW)) u_mden0 (.clk, .en, .a(d2121_s3), .b(d4343_s3),
		.p(pden0));
	llcp_mul #(.AW(DTW), .BW(DTW)) u_mden1 (.clk, .en, .a(d4321_s3), .b(d4321_s3),
		.p(pden1));
	llcp_mul #(.AW(DTW), .BW(DTW)) u_mnum0 (.clk, .en, .a(d1343_s3), .b(d4321_s3),
		.p(pnum0));
	llcp_mul #(.AW(DTW), .BW(DTW)) u_mnum1 (.clk, .en, .a(d1321_s3), .b(d4343_s3),
		.p(pnum1));

	logic signed [DNW-1:0] den, num;
	logic [DNW-1:0]        dmag, nmag, tol_sh;
	logic                  par;
	logic [DNW-1:0]        dmag_s6, nmag_s6;
	logic                  qneg_s6;

	assign den    = DNW'(pden0) - DNW'(pden1);
	assign num    = DNW'(pnum0) - DNW'(pnum1);
	assign dmag   = den[DNW-1] ? (~den + 1'b1) : den;
	assign nmag   = num[DNW-1] ? (~num + 1'b1) : num;
	assign tol_sh = DNW'(tol) << F;
	assign par    = (den == '0) || (d4343_s5 == '0) || (dmag < tol_sh);

	always_ff @(posedge clk) begin
		if (en) begin
			st_s6    <= (st_s5 != ST_OK) ? st_s5 : (par ? ST_PARALLEL : ST_OK);
			dmag_s6  <= dmag;
			nmag_s6  <= nmag;
			qneg_s6  <= den[DNW-1] ^ num[DNW-1];
			p1_s6    <= p1_s5;
			p3_s6    <= p3_s5;
			d21_s6   <= d21_s5;
			d43_s6   <= d43_s5;
			d1343_s6 <= d1343_s5;
			d4321_s6 <= d4321_s5;
			d4343_s6 <= d4343_s5;
		end
	end

	// First division.
	logic                  v_d1;
	logic [CW-1:0]         q_d1;
	logic                  ovf_d1;
	logic [TW1-1:0]        tg_d1;
	logic [1:0]            st_d1;
	logic signed [CW-1:0]  p1_d1 [3], p3_d1 [3];
	logic signed [D-1:0]   d21_d1 [3], d43_d1 [3];
	logic signed [DTW-1:0] d1343_d1, d4321_d1, d4343_d1;
	logic                  qneg_d1;

	llcp_div #(.NW(DNW), .DW(DNW), .QW(CW), .SH(F), .TW(TW1)) u_div_a (
		.clk, .arst_n, .en, .vin(v_s6), .n(nmag_s6), .d(dmag_s6),
		.tin({p1_s6[0], p1_s6[1], p1_s6[2], p3_s6[0], p3_s6[1], p3_s6[2],
			d21_s6[0], d21_s6[1], d21_s6[2], d43_s6[0], d43_s6[1], d43_s6[2],
			st_s6, d1343_s6, d4321_s6, d4343_s6, qneg_s6}),
		.vout(v_d1), .q(q_d1), .ovf(ovf_d1), .tout(tg_d1)
	);

	assign {p1_d1[0], p1_d1[1], p1_d1[2], p3_d1[0], p3_d1[1], p3_d1[2],
		d21_d1[0], d21_d1[1], d21_d1[2], d43_d1[0], d43_d1[1], d43_d1[2],
		st_d1, d1343_d1, d4321_d1, d4343_d1, qneg_d1} = tg_d1;

	logic                  v_s8, v_s9, v_s10, v_s11;
	logic [1:0]            st_s8, st_s9, st_s10, st_s11;
	logic signed [CW-1:0]  mua_s8, mua_s9, mua_s10, mua_s11;
	logic signed [CW-1:0]  p1_s8 [3], p1_s9 [3], p1_s10 [3];
	logic signed [CW-1:0]  p3_s8 [3], p3_s9 [3], p3_s10 [3], p3_s11 [3];
	logic signed [D-1:0]   d21_s8 [3];
	logic signed [D-1:0]   d43_s8 [3], d43_s9 [3], d43_s10 [3], d43_s11 [3];
	logic signed [DTW-1:0] d1343_s8, d1343_s9, d1343_s10;
	logic signed [DTW-1:0] d4321_s8;
	logic signed [DTW-1:0] d4343_s8, d4343_s9, d4343_s10, d4343_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s8  <= v_d1;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// Second parameter numerator product and the points on the first line.
	logic signed [DTW+CW-1:0] pn2;
	logic signed [CW+D-1:0]   ppa [3];

	llcp_mul #(.AW(DTW), .BW(CW)) u_mn2 (.clk, .en, .a(d4321_s8), .b(mua_s8), .p(pn2));

	for (genvar c = 0; c < 3; c++) begin : g_pa
		llcp_mul #(.AW(CW), .BW(D)) u_mpa (.clk, .en, .a(mua_s8), .b(d21_s8[c]),
			.p(ppa[c]));
	end

	logic signed [N2W-1:0] num2;
	logic [N2W-1:0]        n2mag, n2mag_s11;
	logic                  n2neg_s11;
	logic signed [PSW-1:0] pa_sum [3];
	logic signed [CW-1:0]  pa_s11 [3];

	assign num2  = (N2W'(d1343_s10) <<< F) + N2W'(pn2);
	assign n2mag = num2[N2W-1] ? (~num2 + 1'b1) : num2;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pa_sum[c] = (PSW'(p1_s10[c]) <<< F) + PSW'(ppa[c]);
			pa_sum[c] = pa_sum[c] >>> F;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s8    <= st_d1;
			mua_s8   <= sat_q(ovf_d1, q_d1, qneg_d1);
			p1_s8    <= p1_d1;
			p3_s8    <= p3_d1;
			d21_s8   <= d21_d1;
			d43_s8   <= d43_d1;
			d1343_s8 <= d1343_d1;
			d4321_s8 <= d4321_d1;
			d4343_s8 <= d4343_d1;
			st_s9    <= st_s8;
			mua_s9   <= mua_s8;
			p1_s9    <= p1_s8;
			p3_s9    <= p3_s8;
			d43_s9   <= d43_s8;
			d1343_s9 <= d1343_s8;
			d4343_s9 <= d4343_s8;
			st_s10    <= st_s9;
			mua_s10   <= mua_s9;
			p1_s10    <= p1_s9;
			p3_s10    <= p3_s9;
			d43_s10   <= d43_s9;
			d1343_s10 <= d1343_s9;
			d4343_s10 <= d4343_s9;
			st_s11    <= st_s10;
			mua_s11   <= mua_s10;
			p3_s11    <= p3_s10;
			d43_s11   <= d43_s10;
			d4343_s11 <= d4343_s10;
			n2mag_s11 <= n2mag;
			n2neg_s11 <= num2[N2W-1];
			for (int c = 0; c < 3; c++) begin
				pa_s11[c] <= sat_pt(pa_sum[c]);
			end
		end
	end

	// Second division; the squared length of the second line is never negative.
	logic                 v_d2;
	logic [CW-1:0]        q_d2;
	logic                 ovf_d2;
	logic [TW2-1:0]       tg_d2;
	logic signed [CW-1:0] pa_d2 [3], p3_d2 [3];
	logic signed [D-1:0]  d43_d2 [3];
	logic [1:0]           st_d2;
	logic signed [CW-1:0] mua_d2;
	logic                 qneg_d2;

	llcp_div #(.NW(N2W), .DW(DTW), .QW(CW), .SH(0), .TW(TW2)) u_div_b (
		.clk, .arst_n, .en, .vin(v_s11), .n(n2mag_s11), .d(d4343_s11),
		.tin({pa_s11[0], pa_s11[1], pa_s11[2], p3_s11[0], p3_s11[1], p3_s11[2],
			d43_s11[0], d43_s11[1], d43_s11[2], st_s11, mua_s11, n2neg_s11}),
		.vout(v_d2), .q(q_d2), .ovf(ovf_d2), .tout(tg_d2)
	);

	assign {pa_d2[0], pa_d2[1], pa_d2[2], p3_d2[0], p3_d2[1], p3_d2[2],
		d43_d2[0], d43_d2[1], d43_d2[2], st_d2, mua_d2, qneg_d2} = tg_d2;

	logic                 v_s13, v_s14, v_s15, v_s16;
	logic [1:0]           st_s13, st_s14, st_s15;
	logic signed [CW-1:0] mua_s13, mua_s14, mua_s15;
	logic signed [CW-1:0] mub_s13, mub_s14, mub_s15;
	logic signed [CW-1:0] pa_s13 [3], pa_s14 [3], pa_s15 [3];
	logic signed [CW-1:0] p3_s13 [3], p3_s14 [3], p3_s15 [3];
	logic signed [D-1:0]  d43_s13 [3];
	logic signed [CW+D-1:0] ppb [3];
	logic signed [PSW-1:0]  pb_sum [3];

	for (genvar c = 0; c < 3; c++) begin : g_pb
		llcp_mul #(.AW(CW), .BW(D)) u_mpb (.clk, .en, .a(mub_s13), .b(d43_s13[c]),
			.p(ppb[c]));
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pb_sum[c] = (PSW'(p3_s15[c]) <<< F) + PSW'(ppb[c]);
			pb_sum[c] = pb_sum[c] >>> F;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
		end else if (en) begin
			v_s13 <= v_d2;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s13  <= st_d2;
			mua_s13 <= mua_d2;
			mub_s13 <= sat_q(ovf_d2, q_d2, qneg_d2);
			pa_s13  <= pa_d2;
			p3_s13  <= p3_d2;
			d43_s13 <= d43_d2;
			st_s14  <= st_s13;
			mua_s14 <= mua_s13;
			mub_s14 <= mub_s13;
			pa_s14  <= pa_s13;
			p3_s14  <= p3_s13;
			st_s15  <= st_s14;
			mua_s15 <= mua_s14;
			mub_s15 <= mub_s14;
			pa_s15  <= pa_s14;
			p3_s15  <= p3_s14;
			status  <= st_s15;
			if (st_s15 != ST_OK) begin
				param_a <= '0;
				param_b <= '0;
				for (int c = 0; c < 3; c++) begin
					near_a[c] <= '0;
					near_b[c] <= '0;
				end
			end else begin
				param_a <= mua_s15;
				param_b <= mub_s15;
				for (int c = 0; c < 3; c++) begin
					near_a[c] <= pa_s15[c];
					near_b[c] <= sat_pt(pb_sum[c]);
				end
			end
		end
	end

	assign out_valid = v_s16;

endmodule

// ===== rtl/line_line_closest_points_top.sv =====
// Top level of the closest points between two 3D lines block.
//
//   channel   direction  handshake                  transaction when
//   input     in         push / full                push && !full
//   result    out        empty / pop                pop && !empty
//   config    in         cfg_valid / cfg_ready      cfg_valid && cfg_ready
//
// One line pair is accepted every cycle while the input queue is not full; its result passes
// through the two divider pipelines that produce one quotient bit a stage.
// Reset clears the queue, all stage valid flags and sets the tolerance to its default.
// A result not popped holds the whole arithmetic pipeline; the four-entry input queue
// keeps taking line pairs until it fills.
`timescale 1ns / 1ps

module line_line_closest_points_top import llcp_pkg::*; #(
	parameter int COORD_WIDTH = LLCP_COORD_WIDTH,
	parameter int FRAC_BITS = LLCP_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [COORD_WIDTH-1:0] a_start_x,
	input  logic signed [COORD_WIDTH-1:0] a_start_y,
	input  logic signed [COORD_WIDTH-1:0] a_start_z,
	input  logic signed [COORD_WIDTH-1:0] a_end_x,
	input  logic signed [COORD_WIDTH-1:0] a_end_y,
	input  logic signed [COORD_WIDTH-1:0] a_end_z,
	input  logic signed [COORD_WIDTH-1:0] b_start_x,
	input  logic signed [COORD_WIDTH-1:0] b_start_y,
	input  logic signed [COORD_WIDTH-1:0] b_start_z,
	input  logic signed [COORD_WIDTH-1:0] b_end_x,
	input  logic signed [COORD_WIDTH-1:0] b_end_y,
	input  logic signed [COORD_WIDTH-1:0] b_end_z,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    status,
	output logic signed [COORD_WIDTH-1:0] near_a_x,
	output logic signed [COORD_WIDTH-1:0] near_a_y,
	output logic signed [COORD_WIDTH-1:0] near_a_z,
	output logic signed [COORD_WIDTH-1:0] near_b_x,
	output logic signed [COORD_WIDTH-1:0] near_b_y,
	output logic signed [COORD_WIDTH-1:0] near_b_z,
	output logic signed [COORD_WIDTH-1:0] param_a,
	output logic signed [COORD_WIDTH-1:0] param_b,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [LLCP_TOL_WIDTH-1:0]     cfg_data
);

	localparam int EW = 6 * COORD_WIDTH + 9 * (COORD_WIDTH + 1) + 2;

	logic [LLCP_TOL_WIDTH-1:0]    tol_q;
	logic [EW-1:0]                entry_in;
	logic [EW-1:0]                entry_out;
	logic                         q_empty;
	logic                         take;
	logic                         out_valid;
	logic signed [COORD_WIDTH-1:0] near_a [3];
	logic signed [COORD_WIDTH-1:0] near_b [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= LLCP_TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	llcp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.a_start_x, .a_start_y, .a_start_z, .a_end_x, .a_end_y, .a_end_z,
		.b_start_x, .b_start_y, .b_start_z, .b_end_x, .b_end_y, .b_end_z,
		.tol(tol_q), .entry(entry_in)
	);

	llcp_fifo #(.W(EW), .DEPTH(LLCP_QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push, .din(entry_in), .pop(take), .dout(entry_out),
		.full, .empty(q_empty)
	);

	llcp_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .tol(tol_q), .in_valid(!q_empty), .entry(entry_out),
		.in_take(take), .out_pop(pop), .out_valid, .status, .near_a, .near_b,
		.param_a, .param_b
	);

	assign empty    = !out_valid;
	assign near_a_x = near_a[0];
	assign near_a_y = near_a[1];
	assign near_a_z = near_a[2];
	assign near_b_x = near_b[0];
	assign near_b_y = near_b[1];
	assign near_b_z = near_b[2];

endmodule

// ===== rtl/llcp_checker.sv =====
// Port-level checks of the closest points block and their binding to the top level.
`timescale 1ns / 1ps

module llcp_checker import llcp_pkg::*; #(
	parameter int COORD_WIDTH = LLCP_COORD_WIDTH
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          full,
	input logic                          empty,
	input logic                          pop,
	input logic [1:0]                    status,
	input logic signed [COORD_WIDTH-1:0] near_a_x,
	input logic signed [COORD_WIDTH-1:0] near_a_y,
	input logic signed [COORD_WIDTH-1:0] near_a_z,
	input logic signed [COORD_WIDTH-1:0] near_b_x,
	input logic signed [COORD_WIDTH-1:0] near_b_y,
	input logic signed [COORD_WIDTH-1:0] near_b_z,
	input logic signed [COORD_WIDTH-1:0] param_a,
	input logic signed [COORD_WIDTH-1:0] param_b
);

	// A failed line pair carries zero points and parameters.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (near_a_x == '0 && near_a_y == '0 &&
		near_a_z == '0 && near_b_x == '0 && near_b_y == '0 && near_b_z == '0 &&
		param_a == '0 && param_b == '0))
		else $error("failed transaction with nonzero result fields");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(status) && $stable(param_a) &&
		$stable(param_b) && $stable(near_b_z)))
		else $error("waiting result changed before it was taken");

	a_reset_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (empty && !full))
		else $error("queue or result not clear after reset");

endmodule

bind line_line_closest_points_top llcp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_llcp_checker (.*);

// ===== sim/line_line_closest_points_top_test.sv =====
// Testbench for the closest points between two 3D lines block, with a scoreboard class.
`timescale 1ns / 1ps

module line_line_closest_points_top_test;
	import llcp_pkg::*;

	localparam int CW = LLCP_COORD_WIDTH;
	localparam int FB = LLCP_FRAC_BITS;
	localparam int DRAIN_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	typedef logic signed [191:0] wide_t;
	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t as[3];
		coord_t ae[3];
		coord_t bs[3];
		coord_t be[3];
	} line_pair_t;

	typedef struct {
		llcp_status_t status;
		coord_t na[3];
		coord_t nb[3];
		coord_t mua;
		coord_t mub;
	} nearest_t;

	class nearest_scoreboard;
		nearest_t pending[$];
		logic [LLCP_TOL_WIDTH-1:0] tol;
		int errors;
		int checked;
		int seen[4];

		function new();
			tol = LLCP_TOL_RESET;
			errors = 0;
			checked = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function longint mag(longint v);
			return (v < 0) ? -v : v;
		endfunction

		function wide_t sat(wide_t v, int bits);
			wide_t hi;
			wide_t lo;
			hi = (wide_t'(1) <<< (bits - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		function longint dot(longint a[3], longint b[3]);
			wide_t s;
			s = wide_t'(a[0]) * wide_t'(b[0]) + wide_t'(a[1]) * wide_t'(b[1])
				+ wide_t'(a[2]) * wide_t'(b[2]);
			return longint'(sat(s >>> FB, 64));
		endfunction

		function bit all_below(longint v[3]);
			return mag(v[0]) < tol && mag(v[1]) < tol && mag(v[2]) < tol;
		endfunction

		function coord_t on_line(longint base, wide_t mu, longint dir);
			wide_t s;
			s = (wide_t'(base) <<< FB) + mu * wide_t'(dir);
			return coord_t'(sat(s >>> FB, CW));
		endfunction

		function nearest_t closest(line_pair_t p);
			nearest_t r;
			longint d13[3];
			longint d43[3];
			longint d21[3];
			longint d1343, d4321, d1321, d4343, d2121;
			wide_t denom, numer, num2, mua, mub, absd;
			r.status = ST_OK;
			for (int c = 0; c < 3; c++) begin
				r.na[c] = '0;
				r.nb[c] = '0;
				d13[c] = longint'(p.as[c]) - longint'(p.bs[c]);
				d43[c] = longint'(p.be[c]) - longint'(p.bs[c]);
				d21[c] = longint'(p.ae[c]) - longint'(p.as[c]);
			end
			r.mua = '0;
			r.mub = '0;
			if (all_below(d43)) begin
				r.status = ST_B_DEGEN;
				return r;
			end
			if (all_below(d21)) begin
				r.status = ST_A_DEGEN;
				return r;
			end
			d1343 = dot(d13, d43);
			d4321 = dot(d43, d21);
			d1321 = dot(d13, d21);
			d4343 = dot(d43, d43);
			d2121 = dot(d21, d21);
			denom = wide_t'(d2121) * wide_t'(d4343) - wide_t'(d4321) * wide_t'(d4321);
			absd = (denom < 0) ? -denom : denom;
			if (denom == 0 || d4343 == 0 || absd < (wide_t'(tol) <<< FB)) begin
				r.status = ST_PARALLEL;
				return r;
			end
			numer = wide_t'(d1343) * wide_t'(d4321) - wide_t'(d1321) * wide_t'(d4343);
			mua = sat((numer <<< FB) / denom, CW);
			num2 = (wide_t'(d1343) <<< FB) + wide_t'(d4321) * mua;
			mub = sat(num2 / wide_t'(d4343), CW);
			for (int c = 0; c < 3; c++) begin
				r.na[c] = on_line(longint'(p.as[c]), mua, d21[c]);
				r.nb[c] = on_line(longint'(p.bs[c]), mub, d43[c]);
			end
			r.mua = coord_t'(mua);
			r.mub = coord_t'(mub);
			return r;
		endfunction

		function void note_pair(line_pair_t p);
			pending.push_back(closest(p));
		endfunction

		task report(string what, longint got, longint want);
			$display("MISMATCH result %0d %s: got %0d expected %0d", checked, what, got, want);
			errors++;
		endtask

		task check_result(nearest_t got);
			nearest_t want;
			if (pending.size() == 0) begin
				report("unexpected result", got.status, -1);
				return;
			end
			want = pending.pop_front();
			seen[want.status]++;
			if (got.status != want.status) report("status", got.status, want.status);
			for (int c = 0; c < 3; c++) begin
				if (got.na[c] !== want.na[c]) report($sformatf("near_a[%0d]", c), got.na[c], want.na[c]);
				if (got.nb[c] !== want.nb[c]) report($sformatf("near_b[%0d]", c), got.nb[c], want.nb[c]);
			end
			if (got.mua !== want.mua) report("param_a", got.mua, want.mua);
			if (got.mub !== want.mub) report("param_b", got.mub, want.mub);
			checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic push, full, empty, pop;
	logic cfg_valid, cfg_ready;
	logic [LLCP_TOL_WIDTH-1:0] cfg_data;
	line_pair_t drv;
	coord_t near_a_x, near_a_y, near_a_z, near_b_x, near_b_y, near_b_z, param_a, param_b;
	logic [1:0] status;

	nearest_scoreboard sb = new();
	int idle_cycles;
	bit hold_request;
	int hold_left;
	int pop_rate;

	line_line_closest_points_top u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.a_start_x(drv.as[0]), .a_start_y(drv.as[1]), .a_start_z(drv.as[2]),
		.a_end_x(drv.ae[0]), .a_end_y(drv.ae[1]), .a_end_z(drv.ae[2]),
		.b_start_x(drv.bs[0]), .b_start_y(drv.bs[1]), .b_start_z(drv.bs[2]),
		.b_end_x(drv.be[0]), .b_end_y(drv.be[1]), .b_end_z(drv.be[2]),
		.empty(empty), .pop(pop), .status(status),
		.near_a_x(near_a_x), .near_a_y(near_a_y), .near_a_z(near_a_z),
		.near_b_x(near_b_x), .near_b_y(near_b_y), .near_b_z(near_b_z),
		.param_a(param_a), .param_b(param_b),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// The receiver pops at a random rate that it redraws over the run and obeys long hold requests.
	always @(posedge clk) begin
		nearest_t got;
		if (arst_n && pop && !empty) begin
			got.status = llcp_status_t'(status);
			got.na[0] = near_a_x;
			got.na[1] = near_a_y;
			got.na[2] = near_a_z;
			got.nb[0] = near_b_x;
			got.nb[1] = near_b_y;
			got.nb[2] = near_b_z;
			got.mua = param_a;
			got.mub = param_b;
			sb.check_result(got);
		end
		if (($time % 512) < 8) pop_rate = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 90);
		if (hold_request && hold_left == 0) hold_left = HOLD_CYCLES;
		if (hold_left > 0) begin
			hold_left--;
			if (hold_left == 0) hold_request = 0;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(1, 100) <= pop_rate);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	function coord_t near_coord();
		return coord_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
	endfunction

	function coord_t extreme_coord();
		case ($urandom_range(0, 5))
			0: return {1'b0, {(CW-1){1'b1}}};
			1: return {1'b1, {(CW-1){1'b0}}};
			2: return '0;
			3: return '1;
			4: return coord_t'(1);
			default: return coord_t'($urandom());
		endcase
	endfunction

	function coord_t tiny_offset();
		int lim;
		lim = (sb.tol > (1 << 20)) ? (1 << 20) : int'(sb.tol) - 1;
		if (lim <= 0) return '0;
		return coord_t'(int'($urandom_range(0, 2 * lim)) - lim);
	endfunction

	function line_pair_t random_pair();
		line_pair_t p;
		int kind;
		int k;
		kind = $urandom_range(0, 99);
		for (int c = 0; c < 3; c++) begin
			p.as[c] = near_coord();
			p.ae[c] = near_coord();
			p.bs[c] = near_coord();
			p.be[c] = near_coord();
		end
		k = $urandom_range(1, 4);
		for (int c = 0; c < 3; c++) begin
			if (kind < 10) begin
				p.as[c] = $urandom();
				p.ae[c] = $urandom();
				p.bs[c] = $urandom();
				p.be[c] = $urandom();
			end else if (kind < 18) begin
				p.be[c] = p.bs[c] + tiny_offset();
			end else if (kind < 26) begin
				p.ae[c] = p.as[c] + tiny_offset();
			end else if (kind < 36) begin
				p.ae[c] = p.as[c] + coord_t'(int'($urandom_range(0, 4095)) - 2048);
				p.be[c] = p.bs[c] + (p.ae[c] - p.as[c]) * k;
			end else if (kind < 42) begin
				p.as[c] = extreme_coord();
				p.ae[c] = extreme_coord();
				p.bs[c] = extreme_coord();
				p.be[c] = extreme_coord();
			end
		end
		return p;
	endfunction

	function line_pair_t make_pair(coord_t v0, coord_t v1, coord_t v2, coord_t v3);
		line_pair_t p;
		for (int c = 0; c < 3; c++) begin
			p.as[c] = v0;
			p.ae[c] = v1;
			p.bs[c] = v2;
			p.be[c] = v3;
		end
		return p;
	endfunction

	task send_pair(line_pair_t p);
		drv <= p;
		push <= 1'b1;
		do @(posedge clk); while (full);
		sb.note_pair(p);
	endtask

	task end_burst();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task send_random(int count);
		int left;
		while (count > 0) begin
			left = $urandom_range(1, 24);
			while (left > 0 && count > 0) begin
				send_pair(random_pair());
				left--;
				count--;
			end
			end_burst();
		end
		push <= 1'b0;
		@(posedge clk);
	endtask

	task wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_tolerance(logic [LLCP_TOL_WIDTH-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.tol = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam coord_t ONE = coord_t'(1 << FB);

	initial begin
		line_pair_t p;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_request = 0;
		hold_left = 0;
		pop_rate = 100;
		idle_cycles = 0;
		drv = make_pair('0, '0, '0, '0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs under the reset tolerance.
		send_pair(make_pair('0, '0, '0, '0));
		send_pair(make_pair('0, ONE, '0, '0));
		send_pair(make_pair('0, '0, '0, ONE));
		send_pair(make_pair('0, ONE, ONE, 2 * ONE));
		send_pair(make_pair(CMIN, CMAX, CMAX, CMIN));
		send_pair(make_pair(CMAX, CMIN, CMIN, CMAX));
		send_pair(make_pair('1, coord_t'(65), '0, coord_t'(65)));
		p = make_pair('0, '0, '0, '0);
		p.ae[0] = ONE;
		p.bs[2] = ONE;
		p.be[1] = ONE;
		p.be[2] = ONE;
		send_pair(p);
		p.bs[0] = CMAX;
		p.be[0] = CMAX;
		p.ae[0] = coord_t'(1);
		send_pair(p);
		p = make_pair(CMIN, CMAX, CMIN, CMAX);
		p.be[1] = CMIN;
		p.ae[2] = CMIN;
		send_pair(p);
		p = make_pair('0, '0, '0, '0);
		p.ae[0] = ONE;
		p.bs[1] = CMAX;
		p.be[0] = ONE;
		p.be[1] = CMAX;
		p.be[2] = coord_t'(3);
		send_pair(p);
		for (int i = 0; i < 8; i++) send_pair(random_pair());
		push <= 1'b0;
		wait_drained();

		send_random(160);
		hold_request = 1;
		send_random(150);
		wait_drained();

		write_tolerance('0);
		send_random(200);
		wait_drained();

		write_tolerance({LLCP_TOL_WIDTH{1'b1}});
		send_random(80);
		wait_drained();

		write_tolerance(31'(1 << FB));
		send_random(200);
		wait_drained();

		write_tolerance(31'($urandom_range(1, 4096)));
		send_random(200);
		wait_drained();

		write_tolerance(LLCP_TOL_RESET);
		send_random(100);
		wait_drained();

		$display("Checked %0d results over six tolerance settings, one long output stall included.",
			sb.checked);
		$display("Status counts: ok %0d, second degenerate %0d, first degenerate %0d, parallel %0d",
			sb.seen[ST_OK], sb.seen[ST_B_DEGEN], sb.seen[ST_A_DEGEN], sb.seen[ST_PARALLEL]);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/llcp_pkg.sv
rtl/llcp_fifo.sv
rtl/llcp_front.sv
rtl/llcp_mul.sv
rtl/llcp_div.sv
rtl/llcp_back.sv
rtl/line_line_closest_points_top.sv
rtl/llcp_checker.sv
sim/line_line_closest_points_top_test.sv
